// ----- hdl/pllm_pkg.sv -----
package pllm_pkg;

	// Node pool
	localparam int NODE_COUNT = 64;
	localparam int NODE_AW    = 6;
	localparam int PTR_W      = NODE_AW + 1;
	localparam logic [PTR_W-1:0] NIL_NODE = PTR_W'(NODE_COUNT);

	// Head pool
	localparam int HEAD_COUNT = 8;
	localparam int HEAD_AW    = 3;
	localparam int HEAD_PW    = HEAD_AW + 1;
	localparam logic [HEAD_PW-1:0] NIL_HEAD = HEAD_PW'(HEAD_COUNT);

	localparam int ITEM_BITS = 32;
	localparam int CNT_W     = 7;

	// Operation codes
	localparam logic [3:0] ACT_CREATE  = 4'd0;
	localparam logic [3:0] ACT_COUNT   = 4'd1;
	localparam logic [3:0] ACT_FIRST   = 4'd2;
	localparam logic [3:0] ACT_LAST    = 4'd3;
	localparam logic [3:0] ACT_NEXT    = 4'd4;
	localparam logic [3:0] ACT_PREV    = 4'd5;
	localparam logic [3:0] ACT_CURR    = 4'd6;
	localparam logic [3:0] ACT_INS_AFT = 4'd7;
	localparam logic [3:0] ACT_INS_BEF = 4'd8;
	localparam logic [3:0] ACT_APPEND  = 4'd9;
	localparam logic [3:0] ACT_PREPEND = 4'd10;
	localparam logic [3:0] ACT_REMOVE  = 4'd11;
	localparam logic [3:0] ACT_TRIM    = 4'd12;
	localparam logic [3:0] ACT_CONCAT  = 4'd13;
	localparam logic [3:0] ACT_FREE    = 4'd14;

	typedef logic [PTR_W-1:0]     node_ptr_t;
	typedef logic [ITEM_BITS-1:0] item_t;

	typedef struct packed {
		logic [NODE_AW-1:0] nx_ra;
		logic [NODE_AW-1:0] pv_ra;
		logic [NODE_AW-1:0] it_ra;
		logic               nx_we;
		logic [NODE_AW-1:0] nx_wa;
		node_ptr_t          nx_wd;
		logic               pv_we;
		logic [NODE_AW-1:0] pv_wa;
		node_ptr_t          pv_wd;
		logic               it_we;
		logic [NODE_AW-1:0] it_wa;
		item_t              it_wd;
	} node_req_t;

	typedef struct packed {
		node_ptr_t nx;
		node_ptr_t pv;
		item_t     it;
	} node_rsp_t;

endpackage

// ----- hdl/pllm_node_mem.sv -----
// Node link and item memories: one registered read and one write per cycle each
module pllm_node_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  pllm_pkg::node_req_t req,
	output pllm_pkg::node_rsp_t rsp
);

	pllm_pkg::node_ptr_t nx_mem [pllm_pkg::NODE_COUNT];
	pllm_pkg::node_ptr_t pv_mem [pllm_pkg::NODE_COUNT];
	pllm_pkg::item_t     it_mem [pllm_pkg::NODE_COUNT];
	logic [pllm_pkg::NODE_COUNT-1:0] nx_vld_q;
	logic [pllm_pkg::NODE_COUNT-1:0] pv_vld_q;

	// Write ports and registered reads; unwritten next links read as the following node, previous links as NIL
	always_ff @(posedge clk) begin
		if (req.nx_we) begin
			nx_mem[req.nx_wa] <= req.nx_wd;
		end
		if (req.pv_we) begin
			pv_mem[req.pv_wa] <= req.pv_wd;
		end
		if (req.it_we) begin
			it_mem[req.it_wa] <= req.it_wd;
		end
		rsp.nx <= nx_vld_q[req.nx_ra] ? nx_mem[req.nx_ra] :
			({1'b0, req.nx_ra} + pllm_pkg::PTR_W'(1));
		rsp.pv <= pv_vld_q[req.pv_ra] ? pv_mem[req.pv_ra] : pllm_pkg::NIL_NODE;
		rsp.it <= it_mem[req.it_ra];
	end

	// Track written link entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_vld_q <= '0;
			pv_vld_q <= '0;
		end else begin
			if (req.nx_we) begin
				nx_vld_q[req.nx_wa] <= 1'b1;
			end
			if (req.pv_we) begin
				pv_vld_q[req.pv_wa] <= 1'b1;
			end
		end
	end

endmodule

// ----- hdl/pooled_linked_list_manager.sv -----
// Pooled doubly linked list manager. Runs one list operation per input transaction on up
// to 8 lists sharing a pool of 64 nodes, and returns exactly one result transaction per
// operation. Nodes live in single-port-read, single-port-write memories with registered
// reads, so each operation is a short sequence of read and write steps. A new transaction
// is accepted once the previous operation has loaded its result, even while that result
// still waits at the output.
module pooled_linked_list_manager (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [3:0]                     action,
	input  logic [pllm_pkg::HEAD_AW-1:0]   list_handle,
	input  logic [pllm_pkg::HEAD_AW-1:0]   second_handle,
	input  logic [pllm_pkg::ITEM_BITS-1:0] item_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           status,
	output logic [pllm_pkg::ITEM_BITS-1:0] item_out,
	output logic [pllm_pkg::HEAD_AW-1:0]   new_handle,
	output logic [pllm_pkg::CNT_W-1:0]     item_count
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_ITEM  = 4'd2;
	localparam logic [3:0] S_STEP  = 4'd3;
	localparam logic [3:0] S_INS1  = 4'd4;
	localparam logic [3:0] S_INS2  = 4'd5;
	localparam logic [3:0] S_INSW1 = 4'd6;
	localparam logic [3:0] S_INSW2 = 4'd7;
	localparam logic [3:0] S_UNL   = 4'd8;
	localparam logic [3:0] S_UNW1  = 4'd9;
	localparam logic [3:0] S_UNW2  = 4'd10;
	localparam logic [3:0] S_CAT   = 4'd11;
	localparam logic [3:0] S_FR    = 4'd12;
	localparam logic [3:0] S_FRW   = 4'd13;
	localparam logic [3:0] S_FRH   = 4'd14;
	localparam logic [3:0] S_OUT   = 4'd15;

	localparam logic [1:0] INS_TAIL   = 2'd0;
	localparam logic [1:0] INS_HEAD   = 2'd1;
	localparam logic [1:0] INS_AFTER  = 2'd2;
	localparam logic [1:0] INS_BEFORE = 2'd3;

	logic [3:0]                     st_q;
	logic [3:0]                     act_q;
	logic [pllm_pkg::HEAD_AW-1:0]   h_q;
	logic [pllm_pkg::HEAD_AW-1:0]   h2_q;
	pllm_pkg::item_t                val_q;
	pllm_pkg::node_ptr_t            x_q;
	pllm_pkg::node_ptr_t            l_q;
	pllm_pkg::node_ptr_t            r_q;
	pllm_pkg::node_ptr_t            fn_q;
	logic [pllm_pkg::CNT_W-1:0]     lenw_q;
	logic [1:0]                     mode_q;
	logic                           res_status_q;
	pllm_pkg::item_t                res_item_q;
	logic [pllm_pkg::HEAD_AW-1:0]   res_newh_q;

	// List heads and pool tops
	pllm_pkg::node_ptr_t            hp_q  [pllm_pkg::HEAD_COUNT];
	pllm_pkg::node_ptr_t            tp_q  [pllm_pkg::HEAD_COUNT];
	pllm_pkg::node_ptr_t            cp_q  [pllm_pkg::HEAD_COUNT];
	logic [pllm_pkg::CNT_W-1:0]     len_q [pllm_pkg::HEAD_COUNT];
	logic [pllm_pkg::HEAD_COUNT-1:0] pe_q;
	logic [pllm_pkg::HEAD_COUNT-1:0] live_q;
	logic [pllm_pkg::HEAD_PW-1:0]   hfn_q [pllm_pkg::HEAD_COUNT];
	logic [pllm_pkg::HEAD_PW-1:0]   fht_q;
	pllm_pkg::node_ptr_t            fnt_q;

	// Output register
	logic                           out_valid_q;
	logic                           out_status_q;
	pllm_pkg::item_t                out_item_q;
	logic [pllm_pkg::HEAD_AW-1:0]   out_newh_q;
	logic [pllm_pkg::CNT_W-1:0]     out_cnt_q;

	pllm_pkg::node_req_t            req;
	pllm_pkg::node_rsp_t            rsp;

	logic [pllm_pkg::HEAD_AW-1:0]   sel;
	pllm_pkg::node_ptr_t            h_hp;
	pllm_pkg::node_ptr_t            h_tp;
	pllm_pkg::node_ptr_t            h_cp;
	logic [pllm_pkg::CNT_W-1:0]     h_len;
	logic                           h_pe;
	pllm_pkg::node_ptr_t            step_ptr;
	pllm_pkg::node_ptr_t            rm_ptr;
	logic [1:0]                     ins_mode;
	logic                           out_free;
	logic [pllm_pkg::HEAD_AW-1:0]   new_h;

	pllm_node_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Select the head record in use: second list during concat
	assign sel      = (st_q == S_CAT) ? h2_q : h_q;
	assign h_hp     = hp_q[sel];
	assign h_tp     = tp_q[sel];
	assign h_cp     = cp_q[sel];
	assign h_len    = len_q[sel];
	assign h_pe     = pe_q[sel];
	assign step_ptr = (act_q == pllm_pkg::ACT_NEXT) ? rsp.nx : rsp.pv;
	assign rm_ptr   = (act_q == pllm_pkg::ACT_REMOVE) ? h_cp : h_tp;
	assign new_h    = fht_q[pllm_pkg::HEAD_AW-1:0];
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall   = (st_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign item_out   = out_item_q;
	assign new_handle = out_newh_q;
	assign item_count = out_cnt_q;

	// Resolve where an insert goes
	always_comb begin
		ins_mode = INS_TAIL;
		case (act_q)
			pllm_pkg::ACT_PREPEND: ins_mode = INS_HEAD;
			pllm_pkg::ACT_INS_AFT, pllm_pkg::ACT_INS_BEF: begin
				if (h_hp == pllm_pkg::NIL_NODE) begin
					ins_mode = (act_q == pllm_pkg::ACT_INS_AFT) ? INS_TAIL : INS_HEAD;
				end else if (h_cp == pllm_pkg::NIL_NODE) begin
					ins_mode = h_pe ? INS_TAIL : INS_HEAD;
				end else begin
					ins_mode = (act_q == pllm_pkg::ACT_INS_AFT) ? INS_AFTER : INS_BEFORE;
				end
			end
			default: ins_mode = INS_TAIL;
		endcase
	end

	// Drive node memory reads and writes for the current step
	always_comb begin
		req = '0;
		case (st_q)
			S_DEC: begin
				case (act_q)
					pllm_pkg::ACT_FIRST: req.it_ra = h_hp[pllm_pkg::NODE_AW-1:0];
					pllm_pkg::ACT_LAST:  req.it_ra = h_tp[pllm_pkg::NODE_AW-1:0];
					pllm_pkg::ACT_NEXT: begin
						req.it_ra = h_hp[pllm_pkg::NODE_AW-1:0];
						req.nx_ra = h_cp[pllm_pkg::NODE_AW-1:0];
					end
					pllm_pkg::ACT_PREV: begin
						req.it_ra = h_tp[pllm_pkg::NODE_AW-1:0];
						req.pv_ra = h_cp[pllm_pkg::NODE_AW-1:0];
					end
					pllm_pkg::ACT_CURR: req.it_ra = h_cp[pllm_pkg::NODE_AW-1:0];
					pllm_pkg::ACT_REMOVE, pllm_pkg::ACT_TRIM: begin
						req.nx_ra = rm_ptr[pllm_pkg::NODE_AW-1:0];
						req.pv_ra = rm_ptr[pllm_pkg::NODE_AW-1:0];
						req.it_ra = rm_ptr[pllm_pkg::NODE_AW-1:0];
					end
					default: begin
						req.nx_ra = fnt_q[pllm_pkg::NODE_AW-1:0];
						req.pv_ra = h_cp[pllm_pkg::NODE_AW-1:0];
					end
				endcase
			end
			S_STEP: req.it_ra = step_ptr[pllm_pkg::NODE_AW-1:0];
			S_INS1: req.nx_ra = h_cp[pllm_pkg::NODE_AW-1:0];
			S_INSW1: begin
				req.nx_we = 1'b1;
				req.nx_wa = fnt_q[pllm_pkg::NODE_AW-1:0];
				req.nx_wd = r_q;
				req.pv_we = 1'b1;
				req.pv_wa = fnt_q[pllm_pkg::NODE_AW-1:0];
				req.pv_wd = l_q;
				req.it_we = 1'b1;
				req.it_wa = fnt_q[pllm_pkg::NODE_AW-1:0];
				req.it_wd = val_q;
			end
			S_INSW2: begin
				req.nx_we = (l_q != pllm_pkg::NIL_NODE);
				req.nx_wa = l_q[pllm_pkg::NODE_AW-1:0];
				req.nx_wd = fnt_q;
				req.pv_we = (r_q != pllm_pkg::NIL_NODE);
				req.pv_wa = r_q[pllm_pkg::NODE_AW-1:0];
				req.pv_wd = fnt_q;
			end
			S_UNW1, S_FRW: begin
				req.nx_we = 1'b1;
				req.nx_wa = x_q[pllm_pkg::NODE_AW-1:0];
				req.nx_wd = fnt_q;
				req.pv_we = 1'b1;
				req.pv_wa = x_q[pllm_pkg::NODE_AW-1:0];
				req.pv_wd = pllm_pkg::NIL_NODE;
			end
			S_UNW2: begin
				req.nx_we = (l_q != pllm_pkg::NIL_NODE);
				req.nx_wa = l_q[pllm_pkg::NODE_AW-1:0];
				req.nx_wd = r_q;
				req.pv_we = (r_q != pllm_pkg::NIL_NODE);
				req.pv_wa = r_q[pllm_pkg::NODE_AW-1:0];
				req.pv_wd = l_q;
			end
			S_CAT: begin
				req.nx_we = (x_q != pllm_pkg::NIL_NODE) && (h_hp != pllm_pkg::NIL_NODE);
				req.nx_wa = l_q[pllm_pkg::NODE_AW-1:0];
				req.nx_wd = h_hp;
				req.pv_we = req.nx_we;
				req.pv_wa = h_hp[pllm_pkg::NODE_AW-1:0];
				req.pv_wd = l_q;
			end
			S_FR: req.nx_ra = x_q[pllm_pkg::NODE_AW-1:0];
			default: req = '0;
		endcase
	end

	// Sequence each operation and update list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			fnt_q       <= '0;
			fht_q       <= '0;
			pe_q        <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < pllm_pkg::HEAD_COUNT; i++) begin
				hp_q[i]  <= pllm_pkg::NIL_NODE;
				tp_q[i]  <= pllm_pkg::NIL_NODE;
				cp_q[i]  <= pllm_pkg::NIL_NODE;
				len_q[i] <= '0;
				hfn_q[i] <= pllm_pkg::HEAD_PW'(i + 1);
			end
		end else begin
			// drop a result once taken
			if (out_valid_q && !out_stall && st_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q        <= action;
						h_q          <= list_handle;
						h2_q         <= second_handle;
						val_q        <= item_value;
						res_status_q <= 1'b1;
						res_item_q   <= '0;
						res_newh_q   <= '0;
						st_q         <= S_DEC;
					end
				end
				S_DEC: begin
					st_q <= S_OUT;
					if (act_q == pllm_pkg::ACT_CREATE) begin
						if (fht_q != pllm_pkg::NIL_HEAD) begin
							fht_q         <= hfn_q[new_h];
							hfn_q[new_h]  <= pllm_pkg::NIL_HEAD;
							hp_q[new_h]   <= pllm_pkg::NIL_NODE;
							tp_q[new_h]   <= pllm_pkg::NIL_NODE;
							cp_q[new_h]   <= pllm_pkg::NIL_NODE;
							len_q[new_h]  <= '0;
							pe_q[new_h]   <= 1'b0;
							live_q[new_h] <= 1'b1;
							res_status_q  <= 1'b0;
							res_newh_q    <= new_h;
						end
					end else if (live_q[h_q] && act_q <= pllm_pkg::ACT_FREE) begin
						case (act_q)
							pllm_pkg::ACT_COUNT: res_status_q <= 1'b0;
							pllm_pkg::ACT_FIRST, pllm_pkg::ACT_LAST: begin
								cp_q[h_q] <= (act_q == pllm_pkg::ACT_FIRST) ? h_hp : h_tp;
								if (h_hp != pllm_pkg::NIL_NODE) begin
									st_q <= S_ITEM;
								end
							end
							pllm_pkg::ACT_NEXT: begin
								if (h_hp == pllm_pkg::NIL_NODE) begin
									pe_q[h_q] <= 1'b1;
								end else if (h_cp == pllm_pkg::NIL_NODE) begin
									if (!h_pe) begin
										cp_q[h_q] <= h_hp;
										st_q      <= S_ITEM;
									end
								end else if (h_cp == h_tp) begin
									pe_q[h_q] <= 1'b1;
									cp_q[h_q] <= pllm_pkg::NIL_NODE;
								end else begin
									st_q <= S_STEP;
								end
							end
							pllm_pkg::ACT_PREV: begin
								if (h_hp == pllm_pkg::NIL_NODE) begin
									st_q <= S_OUT;
								end else if (h_cp == pllm_pkg::NIL_NODE) begin
									if (h_pe) begin
										cp_q[h_q] <= h_tp;
										st_q      <= S_ITEM;
									end
								end else if (h_cp == h_hp) begin
									pe_q[h_q] <= 1'b0;
									cp_q[h_q] <= pllm_pkg::NIL_NODE;
								end else begin
									st_q <= S_STEP;
								end
							end
							pllm_pkg::ACT_CURR: begin
								if (h_hp != pllm_pkg::NIL_NODE && h_cp != pllm_pkg::NIL_NODE) begin
									st_q <= S_ITEM;
								end
							end
							pllm_pkg::ACT_INS_AFT, pllm_pkg::ACT_INS_BEF,
							pllm_pkg::ACT_APPEND, pllm_pkg::ACT_PREPEND: begin
								mode_q <= ins_mode;
								l_q    <= (ins_mode == INS_TAIL) ? h_tp :
									(ins_mode == INS_AFTER) ? h_cp : pllm_pkg::NIL_NODE;
								r_q    <= (ins_mode == INS_HEAD) ? h_hp :
									(ins_mode == INS_BEFORE) ? h_cp : pllm_pkg::NIL_NODE;
								if (fnt_q != pllm_pkg::NIL_NODE) begin
									st_q <= S_INS1;
								end
							end
							pllm_pkg::ACT_REMOVE, pllm_pkg::ACT_TRIM: begin
								x_q <= rm_ptr;
								if (h_hp != pllm_pkg::NIL_NODE && rm_ptr != pllm_pkg::NIL_NODE) begin
									st_q <= S_UNL;
								end
							end
							pllm_pkg::ACT_CONCAT: begin
								x_q    <= h_hp;
								l_q    <= h_tp;
								lenw_q <= h_len;
								if (live_q[h2_q] && h2_q != h_q) begin
									st_q <= S_CAT;
								end
							end
							default: begin
								x_q  <= h_hp;
								st_q <= (h_hp == pllm_pkg::NIL_NODE) ? S_FRH : S_FR;
							end
						endcase
					end
				end
				S_STEP: begin
					cp_q[h_q] <= step_ptr;
					st_q      <= S_ITEM;
				end
				S_ITEM: begin
					res_status_q <= 1'b0;
					res_item_q   <= rsp.it;
					st_q         <= S_OUT;
				end
				S_INS1: begin
					fn_q <= rsp.nx;
					if (mode_q == INS_BEFORE) begin
						l_q <= rsp.pv;
					end
					st_q <= (mode_q == INS_AFTER) ? S_INS2 : S_INSW1;
				end
				S_INS2: begin
					r_q  <= rsp.nx;
					st_q <= S_INSW1;
				end
				S_INSW1: st_q <= S_INSW2;
				S_INSW2: begin
					if (l_q == pllm_pkg::NIL_NODE) begin
						hp_q[h_q] <= fnt_q;
					end
					if (r_q == pllm_pkg::NIL_NODE) begin
						tp_q[h_q] <= fnt_q;
					end
					cp_q[h_q]    <= fnt_q;
					len_q[h_q]   <= h_len + pllm_pkg::CNT_W'(1);
					fnt_q        <= fn_q;
					res_status_q <= 1'b0;
					st_q         <= S_OUT;
				end
				S_UNL: begin
					l_q          <= rsp.pv;
					r_q          <= rsp.nx;
					res_item_q   <= rsp.it;
					res_status_q <= 1'b0;
					st_q         <= S_UNW1;
				end
				S_UNW1: begin
					fnt_q <= x_q;
					st_q  <= S_UNW2;
				end
				S_UNW2: begin
					if (l_q == pllm_pkg::NIL_NODE) begin
						hp_q[h_q] <= r_q;
					end
					if (r_q == pllm_pkg::NIL_NODE) begin
						tp_q[h_q] <= l_q;
					end
					if (act_q == pllm_pkg::ACT_REMOVE) begin
						cp_q[h_q] <= r_q;
						if (r_q == pllm_pkg::NIL_NODE) begin
							pe_q[h_q] <= 1'b1;
						end
					end else begin
						cp_q[h_q] <= l_q;
					end
					if (h_len != '0) begin
						len_q[h_q] <= h_len - pllm_pkg::CNT_W'(1);
					end
					st_q <= S_OUT;
				end
				S_CAT: begin
					if (x_q == pllm_pkg::NIL_NODE) begin
						hp_q[h_q] <= h_hp;
						tp_q[h_q] <= h_tp;
						pe_q[h_q] <= 1'b0;
					end else if (h_hp != pllm_pkg::NIL_NODE) begin
						tp_q[h_q] <= h_tp;
					end
					len_q[h_q]   <= lenw_q + h_len;
					hp_q[h2_q]   <= pllm_pkg::NIL_NODE;
					tp_q[h2_q]   <= pllm_pkg::NIL_NODE;
					cp_q[h2_q]   <= pllm_pkg::NIL_NODE;
					len_q[h2_q]  <= '0;
					pe_q[h2_q]   <= 1'b0;
					live_q[h2_q] <= 1'b0;
					hfn_q[h2_q]  <= fht_q;
					fht_q        <= {1'b0, h2_q};
					res_status_q <= 1'b0;
					st_q         <= S_OUT;
				end
				S_FR: st_q <= S_FRW;
				S_FRW: begin
					fnt_q <= x_q;
					x_q   <= rsp.nx;
					st_q  <= (rsp.nx == pllm_pkg::NIL_NODE) ? S_FRH : S_FR;
				end
				S_FRH: begin
					hp_q[h_q]    <= pllm_pkg::NIL_NODE;
					tp_q[h_q]    <= pllm_pkg::NIL_NODE;
					cp_q[h_q]    <= pllm_pkg::NIL_NODE;
					len_q[h_q]   <= '0;
					pe_q[h_q]    <= 1'b0;
					live_q[h_q]  <= 1'b0;
					hfn_q[h_q]   <= fht_q;
					fht_q        <= {1'b0, h_q};
					res_status_q <= 1'b0;
					st_q         <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Load the result transaction
	always_ff @(posedge clk) begin
		if (st_q == S_OUT && out_free) begin
			out_status_q <= res_status_q;
			out_item_q   <= res_item_q;
			out_newh_q   <= res_newh_q;
			out_cnt_q    <= (act_q != pllm_pkg::ACT_CREATE && act_q <= pllm_pkg::ACT_FREE
				&& live_q[h_q]) ? h_len : '0;
		end
	end

endmodule

// ----- hdl/pllm_checker.sv -----
// Port-level checks for the list manager
module pllm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           status,
	input logic [pllm_pkg::ITEM_BITS-1:0] item_out,
	input logic [pllm_pkg::HEAD_AW-1:0]   new_handle,
	input logic [pllm_pkg::CNT_W-1:0]     item_count
);

	// One operation in flight: an accepted transaction stalls the next
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an operation was in flight");

	// A failed operation returns no item and no handle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> item_out == '0 && new_handle == '0)
		else $error("failed result carries payload");

	// Lists never hold more than the node pool
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> item_count <= pllm_pkg::CNT_W'(pllm_pkg::NODE_COUNT))
		else $error("item count exceeds node pool");

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(item_out)
			&& $stable(item_count))
		else $error("stalled result changed");

endmodule

bind pooled_linked_list_manager pllm_checker u_pllm_checker (.*);
